### rtl/core/pfc_pkg.sv
// pfc_pkg: shared types and constants for the ppm frame codec
// command codes, register indexes, reset values, config and result structs
// no dependencies
package pfc_pkg;

    localparam int VAL_W     = 16;
    localparam int SUM_W     = 20;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int SET_IDX_W = 3;
    localparam int OUT_IDX_W = 3;
    localparam int SYNC_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TIMER   = 2'd0,
        CMD_CAPTURE = 2'd1,
        CMD_SET     = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECODE_MODE   = 3'd0,
        REG_MARK_LENGTH   = 3'd1,
        REG_FRAME_LENGTH  = 3'd2,
        REG_MIN_PULSE     = 3'd3,
        REG_MAX_PULSE     = 3'd4,
        REG_FLOOR_VALUE   = 3'd5,
        REG_SYNC_GAP      = 3'd6,
        REG_DEFAULT_VALUE = 3'd7
    } cfg_reg_t;

    localparam logic             RST_DECODE_MODE   = 1'b1;
    localparam logic [VAL_W-1:0] RST_MARK_LENGTH   = 16'd400;
    localparam logic [VAL_W-1:0] RST_FRAME_LENGTH  = 16'd20000;
    localparam logic [VAL_W-1:0] RST_MIN_PULSE     = 16'd500;
    localparam logic [VAL_W-1:0] RST_MAX_PULSE     = 16'd2500;
    localparam logic [VAL_W-1:0] RST_FLOOR_VALUE   = 16'd1000;
    localparam logic [VAL_W-1:0] RST_SYNC_GAP      = 16'd3000;
    localparam logic [VAL_W-1:0] RST_DEFAULT_VALUE = 16'd1500;

    typedef struct packed {
        logic             decode_mode;
        logic [VAL_W-1:0] mark_length;
        logic [VAL_W-1:0] frame_length;
        logic [VAL_W-1:0] min_pulse;
        logic [VAL_W-1:0] max_pulse;
        logic [VAL_W-1:0] floor_value;
        logic [VAL_W-1:0] sync_gap;
        logic [VAL_W-1:0] default_value;
    } cfg_t;

    typedef struct packed {
        logic             segment_valid;
        logic             pin_level;
        logic [VAL_W-1:0] segment_length;
        logic             frame_done;
    } enc_res_t;

    typedef struct packed {
        logic                 channel_written;
        logic [OUT_IDX_W-1:0] decoded_index;
        logic [VAL_W-1:0]     decoded_value;
        logic                 defaults_loaded;
        logic                 frame_done;
        logic [SYNC_W-1:0]    sync_position;
        logic                 signal_seen;
    } dec_res_t;

endpackage

### rtl/core/pfc_cfg_regs.sv
// pfc_cfg_regs: configuration register file of the ppm frame codec
// depends on pfc_pkg
module pfc_cfg_regs
    import pfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DECODE_MODE:   cfg_next.decode_mode   = cfg_data[0];
                REG_MARK_LENGTH:   cfg_next.mark_length   = cfg_data;
                REG_FRAME_LENGTH:  cfg_next.frame_length  = cfg_data;
                REG_MIN_PULSE:     cfg_next.min_pulse     = cfg_data;
                REG_MAX_PULSE:     cfg_next.max_pulse     = cfg_data;
                REG_FLOOR_VALUE:   cfg_next.floor_value   = cfg_data;
                REG_SYNC_GAP:      cfg_next.sync_gap      = cfg_data;
                REG_DEFAULT_VALUE: cfg_next.default_value = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decode_mode   <= RST_DECODE_MODE;
            cfg_reg.mark_length   <= RST_MARK_LENGTH;
            cfg_reg.frame_length  <= RST_FRAME_LENGTH;
            cfg_reg.min_pulse     <= RST_MIN_PULSE;
            cfg_reg.max_pulse     <= RST_MAX_PULSE;
            cfg_reg.floor_value   <= RST_FLOOR_VALUE;
            cfg_reg.sync_gap      <= RST_SYNC_GAP;
            cfg_reg.default_value <= RST_DEFAULT_VALUE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/pfc_encoder.sv
// pfc_encoder: frame generator with the output channel table and running sum
// depends on pfc_pkg
module pfc_encoder
    import pfc_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [CMD_W-1:0]     command,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [VAL_W-1:0]     set_value,
    input  cfg_t                 cfg,
    output enc_res_t             res
);

    localparam int STEP_W = $clog2(2 * NUM_CHANNELS + 2);
    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_CHANNELS + 1);
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

    logic [VAL_W-1:0]  table_reg [NUM_CHANNELS];
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    logic              enc_go;
    logic              set_ok;
    logic [4:0]        set_idx_ext;
    logic [VAL_W-1:0]  chan_width;
    logic [VAL_W-1:0]  add_len;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  frame_ext;

    assign enc_go      = fire && (command == CMD_TIMER) && !cfg.decode_mode;
    assign set_idx_ext = 5'(set_index);
    assign set_ok      = fire && (command == CMD_SET) && (set_idx_ext < 5'(NUM_CHANNELS));
    // odd step reads channel (step+1)/2-1, which is step>>1 for an odd step
    assign chan_width  = table_reg[step_reg[IDX_W:1]];
    assign frame_ext   = SUM_W'(cfg.frame_length);

    always_comb
    begin
        res       = '0;
        step_next = step_reg;
        sum_next  = sum_reg;
        add_len   = '0;
        sum_add   = '0;
        if (step_reg >= LAST_STEP)
        begin
            res.segment_length = (frame_ext > sum_reg) ? VAL_W'(frame_ext - sum_reg) : '0;
            res.frame_done     = 1'b1;
        end
        else
        begin
            if (!step_reg[0])
            begin
                add_len       = cfg.mark_length;
                res.pin_level = 1'b1;
            end
            else
            begin
                add_len = (chan_width > cfg.mark_length) ? chan_width - cfg.mark_length : '0;
            end
            res.segment_length = add_len;
        end
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(add_len);
        if (enc_go)
        begin
            res.segment_valid = 1'b1;
            if (step_reg >= LAST_STEP)
            begin
                step_next = '0;
                sum_next  = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
                sum_next  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
        end
        else
        begin
            res = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            step_reg <= step_next;
            sum_reg  <= sum_next;
            if (set_ok)
            begin
                table_reg[set_idx_ext[IDX_W-1:0]] <= set_value;
            end
        end
    end

endmodule

### rtl/core/pfc_decoder.sv
// pfc_decoder: capture interval decoder with frame position and signal flag
// depends on pfc_pkg
module pfc_decoder
    import pfc_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [CMD_W-1:0] command,
    input  logic [VAL_W-1:0] capture_interval,
    input  cfg_t             cfg,
    output dec_res_t         res
);

    localparam int POS_W = $clog2(NUM_CHANNELS + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_CHANNELS);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_mid;
    logic             seen_reg;
    logic             seen_next;
    logic [VAL_W:0]   chan_raw;
    logic [VAL_W:0]   floor_ext;
    logic [VAL_W:0]   chan_val;
    logic             in_window;

    assign chan_raw  = (VAL_W + 1)'(capture_interval) + 1'b1;
    assign floor_ext = (VAL_W + 1)'(cfg.floor_value);
    assign chan_val  = (chan_raw < floor_ext) ? floor_ext : chan_raw;
    assign in_window = (capture_interval > cfg.min_pulse) && (capture_interval < cfg.max_pulse);

    always_comb
    begin
        res       = '0;
        pos_mid   = pos_reg;
        pos_next  = pos_reg;
        seen_next = seen_reg;
        if (fire && cfg.decode_mode && (command == CMD_TIMER))
        begin
            pos_next = '0;
            if (!seen_reg)
            begin
                res.defaults_loaded = 1'b1;
                res.decoded_value   = cfg.default_value;
            end
        end
        else if (fire && cfg.decode_mode && (command == CMD_CAPTURE))
        begin
            if (pos_reg != '0)
            begin
                if (in_window)
                begin
                    res.channel_written = 1'b1;
                    res.decoded_index   = OUT_IDX_W'(pos_reg - 1'b1);
                    res.decoded_value   = chan_val[VAL_W-1:0];
                    seen_next           = 1'b1;
                    if (pos_reg < POS_LAST)
                    begin
                        pos_mid = pos_reg + 1'b1;
                    end
                    else
                    begin
                        pos_mid        = '0;
                        res.frame_done = 1'b1;
                    end
                end
                else
                begin
                    pos_mid = '0;
                end
            end
            // the same interval may open a new frame right after an abort or frame end
            pos_next = ((pos_mid == '0) && (capture_interval > cfg.sync_gap))
                       ? POS_W'(1) : pos_mid;
        end
        res.sync_position = SYNC_W'(pos_next);
        res.signal_seen   = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
        end
    end

endmodule

### rtl/core/ppm_frame_codec_unit.sv
// ppm_frame_codec_unit: top level of the ppm frame codec
// depends on pfc_pkg, pfc_cfg_regs, pfc_encoder, pfc_decoder
//
// Takes one item per clock cycle and returns exactly one result per item.
// Each item is latched in an input register, the encoder and decoder state is
// updated in a single pass of logic, and the result lands in an output register.
// The output register lets the next item be taken while a result waits; both
// registers full with out_ready low stops input transfers. Configuration writes
// take effect on the next cycle and are meant for an idle codec. No clearing
// pass after reset.
module ppm_frame_codec_unit
    import pfc_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [VAL_W-1:0]     capture_interval,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [VAL_W-1:0]     set_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 segment_valid,
    output logic                 pin_level,
    output logic [VAL_W-1:0]     segment_length,
    output logic                 channel_written,
    output logic [OUT_IDX_W-1:0] decoded_index,
    output logic [VAL_W-1:0]     decoded_value,
    output logic                 defaults_loaded,
    output logic                 frame_done,
    output logic [SYNC_W-1:0]    sync_position,
    output logic                 signal_seen
);

    cfg_t cfg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [CMD_W-1:0]     command_reg;
    logic [VAL_W-1:0]     interval_reg;
    logic [SET_IDX_W-1:0] set_index_reg;
    logic [VAL_W-1:0]     set_value_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    enc_res_t             enc_res;
    dec_res_t             dec_res;
    enc_res_t             enc_res_reg;
    dec_res_t             dec_res_reg;

    logic                 advance;
    logic                 in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    pfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfc_encoder #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_enc (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .command   (command_reg),
        .set_index (set_index_reg),
        .set_value (set_value_reg),
        .cfg       (cfg),
        .res       (enc_res)
    );

    pfc_decoder #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dec (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .command          (command_reg),
        .capture_interval (interval_reg),
        .cfg              (cfg),
        .res              (dec_res)
    );

    always_comb
    begin
        in_valid_next = in_xfer || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            command_reg   <= command;
            interval_reg  <= capture_interval;
            set_index_reg <= set_index;
            set_value_reg <= set_value;
        end
        if (advance)
        begin
            enc_res_reg <= enc_res;
            dec_res_reg <= dec_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign segment_valid   = enc_res_reg.segment_valid;
    assign pin_level       = enc_res_reg.pin_level;
    assign segment_length  = enc_res_reg.segment_length;
    assign channel_written = dec_res_reg.channel_written;
    assign decoded_index   = dec_res_reg.decoded_index;
    assign decoded_value   = dec_res_reg.decoded_value;
    assign defaults_loaded = dec_res_reg.defaults_loaded;
    assign frame_done      = enc_res_reg.frame_done | dec_res_reg.frame_done;
    assign sync_position   = dec_res_reg.sync_position;
    assign signal_seen     = dec_res_reg.signal_seen;

    // a processed item always leaves a result behind
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after item was processed");

    // encoder and decoder never report in the same result
    a_one_unit_reports: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(enc_res_reg.segment_valid &&
                            (dec_res_reg.channel_written || dec_res_reg.defaults_loaded)))
        else $error("encoder and decoder both reported in one result");

    // a held input item is never overwritten while the result side is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !in_ready)
        else $error("input register accepted a transfer while still holding an item");

endmodule

### sim/tb_ppm_frame_codec_unit.sv
`timescale 1ns / 100ps
// tb_ppm_frame_codec_unit: self-checking bench for the ppm frame codec, encode and decode modes
// a queue-fed driver, an in-bench predictor of each result and a field-by-field monitor
// depends on pfc_pkg and ppm_frame_codec_unit
module tb_ppm_frame_codec_unit;
    import pfc_pkg::*;

    localparam int NUM_CH       = 8;
    localparam int CH_IDX_W     = $clog2(NUM_CH);
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 98;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_MAX = 1000;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam logic [SUM_W-1:0] SUM_SAT      = '1;

    typedef enum logic {OP_ITEM, OP_CFG} op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [CMD_W-1:0]     command;
        logic [VAL_W-1:0]     capture_interval;
        logic [SET_IDX_W-1:0] set_index;
        logic [VAL_W-1:0]     set_value;
        cfg_reg_t             cfg_index;
        logic [VAL_W-1:0]     cfg_data;
    } codec_op_t;

    typedef struct packed {
        logic                 segment_valid;
        logic                 pin_level;
        logic [VAL_W-1:0]     segment_length;
        logic                 channel_written;
        logic [OUT_IDX_W-1:0] decoded_index;
        logic [VAL_W-1:0]     decoded_value;
        logic                 defaults_loaded;
        logic                 frame_done;
        logic [SYNC_W-1:0]    sync_position;
        logic                 signal_seen;
    } codec_result_t;

    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [VAL_W-1:0]     cfg_data         = '0;
    logic                 in_valid         = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command          = '0;
    logic [VAL_W-1:0]     capture_interval = '0;
    logic [SET_IDX_W-1:0] set_index        = '0;
    logic [VAL_W-1:0]     set_value        = '0;
    logic                 out_valid;
    logic                 out_ready        = 1'b0;
    logic                 segment_valid;
    logic                 pin_level;
    logic [VAL_W-1:0]     segment_length;
    logic                 channel_written;
    logic [OUT_IDX_W-1:0] decoded_index;
    logic [VAL_W-1:0]     decoded_value;
    logic                 defaults_loaded;
    logic                 frame_done;
    logic [SYNC_W-1:0]    sync_position;
    logic                 signal_seen;

    codec_op_t     pending_ops[$];
    codec_result_t expected_results[$];

    // predictor copy of the codec state and registers
    cfg_t              cfg_model;
    logic [VAL_W-1:0]  chan_width [NUM_CH];
    logic [4:0]        frame_step;
    logic [SUM_W-1:0]  frame_sum;
    logic [SYNC_W-1:0] dec_pos;
    logic              seen;

    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;
    int unsigned results_checked = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;

    ppm_frame_codec_unit #(.NUM_CHANNELS(NUM_CH)) i_dut (.*);

    always #4 clk = ~clk;

    function automatic codec_result_t next_codec_result(input codec_op_t it);
        codec_result_t       r;
        logic [5:0]          step_n;
        logic [SUM_W:0]      sum_n;
        logic [VAL_W-1:0]    len;
        logic [VAL_W-1:0]    width;
        logic [VAL_W:0]      value;
        logic [CH_IDX_W-1:0] ch_idx;
        r = '0;
        if (it.command == CMD_SET) begin
            if (it.set_index < NUM_CH)
                chan_width[it.set_index] = it.set_value;
        end else if (it.command == CMD_TIMER && !cfg_model.decode_mode) begin
            step_n = {1'b0, frame_step} + 6'd1;
            r.segment_valid = 1'b1;
            if (step_n >= 2 * NUM_CH + 2) begin
                // closing gap of the frame, saturates at zero
                len = (SUM_W'(cfg_model.frame_length) > frame_sum) ?
                      cfg_model.frame_length - frame_sum[VAL_W-1:0] : '0;
                frame_sum = '0;
                frame_step = '0;
                r.frame_done = 1'b1;
            end else begin
                if (step_n[0]) begin
                    len = cfg_model.mark_length;
                    r.pin_level = 1'b1;
                end else begin
                    ch_idx = CH_IDX_W'((step_n / 2 - 1) % NUM_CH);
                    width = chan_width[ch_idx];
                    len = (width > cfg_model.mark_length) ? width - cfg_model.mark_length : '0;
                end
                sum_n = {1'b0, frame_sum} + (SUM_W + 1)'(len);
                frame_sum = sum_n[SUM_W] ? SUM_SAT : sum_n[SUM_W-1:0];
                frame_step = step_n[4:0];
            end
            r.segment_length = len;
        end else if (it.command == CMD_TIMER) begin
            dec_pos = '0;
            if (!seen) begin
                r.defaults_loaded = 1'b1;
                r.decoded_value = cfg_model.default_value;
            end
        end else if (it.command == CMD_CAPTURE && cfg_model.decode_mode) begin
            if (dec_pos != 0) begin
                if (it.capture_interval > cfg_model.min_pulse &&
                    it.capture_interval < cfg_model.max_pulse) begin
                    value = {1'b0, it.capture_interval} + 17'd1;
                    if (value < {1'b0, cfg_model.floor_value})
                        value = {1'b0, cfg_model.floor_value};
                    r.channel_written = 1'b1;
                    r.decoded_index = dec_pos[OUT_IDX_W-1:0] - 1'b1;
                    r.decoded_value = value[VAL_W-1:0];
                    if (dec_pos < NUM_CH) begin
                        dec_pos = dec_pos + 1'b1;
                    end else begin
                        dec_pos = '0;
                        r.frame_done = 1'b1;
                    end
                    seen = 1'b1;
                end else begin
                    dec_pos = '0;
                end
            end
            // the interval that closed a frame may open the next one
            if (dec_pos == 0 && it.capture_interval > cfg_model.sync_gap)
                dec_pos = SYNC_W'(1);
        end
        r.sync_position = dec_pos;
        r.signal_seen = seen;
        return r;
    endfunction

    // fields a command does not use carry random bits
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] ivl,
                             input logic [SET_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        codec_op_t op;
        op = '0;
        op.kind = OP_ITEM;
        op.command = cmd;
        op.capture_interval = (cmd == CMD_CAPTURE) ? ivl : VAL_W'($urandom_range(0, 65535));
        op.set_index = (cmd == CMD_SET) ? idx : SET_IDX_W'($urandom_range(0, 7));
        op.set_value = (cmd == CMD_SET) ? val : VAL_W'($urandom_range(0, 65535));
        pending_ops.push_back(op);
    endtask

    task automatic push_cfg(input cfg_reg_t idx, input logic [VAL_W-1:0] data);
        codec_op_t op;
        op = '0;
        op.kind = OP_CFG;
        op.cfg_index = idx;
        op.cfg_data = data;
        pending_ops.push_back(op);
    endtask

    function automatic logic [VAL_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : send_proc
        logic took;
        if (!rst_n) begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            command <= '0;
            capture_interval <= '0;
            set_index <= '0;
            set_value <= '0;
            cfg_index <= '0;
            cfg_data <= '0;
            cfg_model.decode_mode = RST_DECODE_MODE;
            cfg_model.mark_length = RST_MARK_LENGTH;
            cfg_model.frame_length = RST_FRAME_LENGTH;
            cfg_model.min_pulse = RST_MIN_PULSE;
            cfg_model.max_pulse = RST_MAX_PULSE;
            cfg_model.floor_value = RST_FLOOR_VALUE;
            cfg_model.sync_gap = RST_SYNC_GAP;
            cfg_model.default_value = RST_DEFAULT_VALUE;
            for (int i = 0; i < NUM_CH; i++)
                chan_width[i] = '0;
            frame_step = '0;
            frame_sum = '0;
            dec_pos = '0;
            seen = 1'b0;
            send_gap = 0;
        end else begin
            took = 1'b0;
            if (in_valid && in_ready) begin
                expected_results.push_back(next_codec_result(pending_ops.pop_front()));
                took = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (pending_ops[0].cfg_index)
                    REG_DECODE_MODE:   cfg_model.decode_mode   = pending_ops[0].cfg_data[0];
                    REG_MARK_LENGTH:   cfg_model.mark_length   = pending_ops[0].cfg_data;
                    REG_FRAME_LENGTH:  cfg_model.frame_length  = pending_ops[0].cfg_data;
                    REG_MIN_PULSE:     cfg_model.min_pulse     = pending_ops[0].cfg_data;
                    REG_MAX_PULSE:     cfg_model.max_pulse     = pending_ops[0].cfg_data;
                    REG_FLOOR_VALUE:   cfg_model.floor_value   = pending_ops[0].cfg_data;
                    REG_SYNC_GAP:      cfg_model.sync_gap      = pending_ops[0].cfg_data;
                    REG_DEFAULT_VALUE: cfg_model.default_value = pending_ops[0].cfg_data;
                    default: ;
                endcase
                void'(pending_ops.pop_front());
                took = 1'b1;
            end
            // an offer that was not taken stays as it is
            if ((!in_valid || in_ready) && (!cfg_valid || cfg_ready)) begin
                if (took && pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 4);
                if (send_gap > 0 || pending_ops.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end else if (pending_ops[0].kind == OP_ITEM) begin
                    in_valid <= 1'b1;
                    cfg_valid <= 1'b0;
                    command <= pending_ops[0].command;
                    capture_interval <= pending_ops[0].capture_interval;
                    set_index <= pending_ops[0].set_index;
                    set_value <= pending_ops[0].set_value;
                end else begin
                    // register writes only once every result is back
                    in_valid <= 1'b0;
                    cfg_valid <= (expected_results.size() == 0);
                    cfg_index <= pending_ops[0].cfg_index;
                    cfg_data <= pending_ops[0].cfg_data;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : recv_proc
        codec_result_t want;
        codec_result_t got;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = {segment_valid, pin_level, segment_length, channel_written, decoded_index,
                       decoded_value, defaults_loaded, frame_done, sync_position, signal_seen};
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("segment_valid", 32'(want.segment_valid),
                                32'(got.segment_valid));
                    check_field("pin_level", 32'(want.pin_level), 32'(got.pin_level));
                    check_field("segment_length", 32'(want.segment_length),
                                32'(got.segment_length));
                    check_field("channel_written", 32'(want.channel_written),
                                32'(got.channel_written));
                    check_field("decoded_index", 32'(want.decoded_index),
                                32'(got.decoded_index));
                    check_field("decoded_value", 32'(want.decoded_value),
                                32'(got.decoded_value));
                    check_field("defaults_loaded", 32'(want.defaults_loaded),
                                32'(got.defaults_loaded));
                    check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                    check_field("sync_position", 32'(want.sync_position),
                                32'(got.sync_position));
                    check_field("signal_seen", 32'(want.signal_seen), 32'(got.signal_seen));
                    results_checked++;
                    // long hold-off so the codec fills up and stalls its input
                    if (results_checked == 300 || results_checked == 750)
                        recv_stall = LONG_HOLD;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
            (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles == WATCHDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_MAX);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial
    begin : stimulus
        int unsigned      target;
        int unsigned      k;
        logic             mode;
        logic [VAL_W-1:0] mark, frame, lo, hi, flr, sync, dflt;

        // decode mode out of reset
        push_item(CMD_TIMER, '0, '0, '0);          // timeout before any signal
        push_item(CMD_RESERVED, '0, '0, '0);
        push_item(CMD_CAPTURE, 16'hFFFF, '0, '0);
        push_item(CMD_CAPTURE, 16'd501, '0, '0);   // just above min, raised to floor
        push_item(CMD_CAPTURE, 16'd500, '0, '0);   // at min, frame aborted
        push_item(CMD_CAPTURE, 16'd3001, '0, '0);  // just above sync gap
        push_item(CMD_CAPTURE, 16'd2500, '0, '0);  // at max, frame aborted
        push_item(CMD_CAPTURE, 16'hFFFF, '0, '0);
        push_item(CMD_CAPTURE, 16'd2499, '0, '0);
        for (k = 0; k < NUM_CH - 1; k++)
            push_item(CMD_CAPTURE, VAL_W'(1500 + k), '0, '0);
        push_item(CMD_TIMER, '0, '0, '0);          // timeout after a signal was seen
        push_item(CMD_CAPTURE, 16'd0, '0, '0);
        push_item(CMD_SET, '0, 3'd0, 16'd0);
        push_item(CMD_SET, '0, 3'd7, 16'hFFFF);
        push_item(CMD_SET, '0, 3'd1, 16'd1000);
        push_cfg(REG_DECODE_MODE, 16'd0);
        push_item(CMD_TIMER, '0, '0, '0);
        push_item(CMD_TIMER, '0, '0, '0);          // zero-width channel clamps to zero length
        push_item(CMD_CAPTURE, 16'h5A5A, '0, '0);  // ignored while encoding
        push_item(CMD_TIMER, '0, '0, '0);
        push_item(CMD_TIMER, '0, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            mode = (p % 2 == 0);
            if (p == 4 || p == 9) begin
                mark = extreme_value();
                frame = extreme_value();
                lo = extreme_value();
                hi = extreme_value();
                flr = extreme_value();
                sync = extreme_value();
                dflt = extreme_value();
            end else begin
                mark = VAL_W'($urandom_range(0, 1000));
                frame = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 3000)) :
                                                      VAL_W'($urandom_range(5000, 40000));
                lo = VAL_W'($urandom_range(0, 1500));
                hi = VAL_W'(lo + $urandom_range(2, 2500));
                flr = VAL_W'($urandom_range(0, 3000));
                // a sync gap inside the channel window lets a last channel restart the frame
                sync = (p == 2 || $urandom_range(0, 3) == 0) ? VAL_W'(lo + 1) :
                                                               VAL_W'(hi + $urandom_range(0, 4000));
                dflt = VAL_W'($urandom_range(0, 65535));
            end
            push_cfg(REG_DECODE_MODE, mode ? 16'd1 : 16'd0);
            push_cfg(REG_MARK_LENGTH, mark);
            push_cfg(REG_FRAME_LENGTH, frame);
            push_cfg(REG_MIN_PULSE, lo);
            push_cfg(REG_MAX_PULSE, hi);
            push_cfg(REG_FLOOR_VALUE, flr);
            push_cfg(REG_SYNC_GAP, sync);
            push_cfg(REG_DEFAULT_VALUE, dflt);

            target = pending_ops.size() + PHASE_ITEMS;
            while (pending_ops.size() < target) begin
                if (mode) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            // sync interval then a run of channels, mostly a full frame
                            push_item(CMD_CAPTURE,
                                      (sync == '1) ? sync :
                                                     VAL_W'($urandom_range(sync + 1, 65535)),
                                      '0, '0);
                            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : NUM_CH;
                            repeat (k)
                                push_item(CMD_CAPTURE, (hi > lo + 1) ?
                                          VAL_W'($urandom_range(lo + 1, hi - 1)) :
                                          VAL_W'($urandom_range(0, 65535)), '0, '0);
                        end
                        6:       push_item(CMD_TIMER, '0, '0, '0);
                        7:       push_item(CMD_SET, '0, SET_IDX_W'($urandom_range(0, 7)),
                                           VAL_W'($urandom_range(0, 65535)));
                        8:       push_item(CMD_CAPTURE, VAL_W'($urandom_range(0, 65535)),
                                           '0, '0);
                        default: push_item(CMD_RESERVED, '0, '0, '0);
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: push_item(CMD_TIMER, '0, '0, '0);
                        6, 7: push_item(CMD_SET, '0, SET_IDX_W'($urandom_range(0, 7)),
                                        ($urandom_range(0, 3) == 0) ?
                                        VAL_W'($urandom_range(0, 65535)) :
                                        VAL_W'($urandom_range(0, 3000)));
                        8:       push_item(CMD_CAPTURE, VAL_W'($urandom_range(0, 65535)),
                                           '0, '0);
                        default: push_item(CMD_RESERVED, '0, '0, '0);
                    endcase
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
